>>> rtl/wrapping_page_bitmap_blitter_defines.svh
// assertion macros for the wrapping page bitmap blitter
// expects signals named clk and rst_n in the module that includes it
`ifndef WRAPPING_PAGE_BITMAP_BLITTER_DEFINES_SVH
`define WRAPPING_PAGE_BITMAP_BLITTER_DEFINES_SVH

// property must hold on every clock edge out of reset
`define WPBB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define WPBB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/wpbb_pkg.sv
// shared constants, types and helper functions of the page bitmap blitter
// no dependencies
package wpbb_pkg;

  // screen geometry
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int SCREEN_PAGES  = SCREEN_HEIGHT / 8;
  localparam int WRAP_GAP      = 64;

  // field widths
  localparam int COL_W   = 13;
  localparam int PAGE_W  = 5;
  localparam int NPAGE_W = 6;
  localparam int YOFF_W  = 8;
  localparam int SCRL_W  = 16;
  localparam int SPAGE_W = 3;
  localparam int SCOL_W  = 7;
  localparam int BYTE_W  = 8;

  // internal widths
  localparam int D_W        = 18;          // column minus scroll, signed
  localparam int B_W        = 10;          // row of the top pixel, signed
  localparam int P_W        = B_W - 3;     // screen page of the top pixel, signed
  localparam int MAG_W      = 16;          // magnitude of the column difference
  localparam int MOD_W      = 14;          // wrap period, up to width plus gap
  localparam int QUO_W      = 8;           // quotient bits resolved by the modulo pipe
  localparam int MOD_STAGES = QUO_W / 2;   // two quotient bits per stage

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_BITMAP_WIDTH = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BITMAP_PAGES = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_Y_OFFSET     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SCROLL_X     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FLIP         = 3'd4;

  localparam int RST_BITMAP_WIDTH = 128;
  localparam int RST_BITMAP_PAGES = 2;

  // per-item information that travels alongside the modulo pipe
  typedef struct packed {
    logic               kill;
    logic               neg;
    logic               nw_ok;
    logic [SCOL_W-1:0]  nw_x;
    logic               a_v;
    logic [SPAGE_W-1:0] a_pg;
    logic [BYTE_W-1:0]  a_m;
    logic               b_v;
    logic [SPAGE_W-1:0] b_pg;
    logic [BYTE_W-1:0]  b_m;
  } side_t;

  function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    for (int i = 0; i < BYTE_W; i++) begin
      r[i] = b[BYTE_W-1-i];
    end
    return r;
  endfunction

  // one restoring step: subtract modulus shifted by k when it fits
  function automatic logic [MAG_W-1:0] mod_step(input logic [MAG_W-1:0] rem,
                                                input logic [MOD_W-1:0] m,
                                                input int unsigned      k);
    logic [MAG_W+QUO_W-1:0] w;
    logic [MAG_W+QUO_W-1:0] r;
    w = (MAG_W+QUO_W)'(m) << k;
    r = (MAG_W+QUO_W)'(rem);
    if (r >= w) begin
      r = r - w;
    end
    return r[MAG_W-1:0];
  endfunction

endpackage

>>> rtl/wpbb_in_if.sv
// input channel of the page bitmap blitter: one bitmap byte per transaction
// depends on wpbb_pkg
interface wpbb_in_if;
  logic                           valid;
  logic                           ready;
  logic [wpbb_pkg::COL_W-1:0]     src_column;
  logic [wpbb_pkg::PAGE_W-1:0]    src_page;
  logic [wpbb_pkg::BYTE_W-1:0]    src_byte;

  modport source (output valid, src_column, src_page, src_byte, input ready);
  modport sink   (input valid, src_column, src_page, src_byte, output ready);
endinterface

>>> rtl/wpbb_out_if.sv
// result channel of the page bitmap blitter: one framebuffer or-mask per transaction
// depends on wpbb_pkg
interface wpbb_out_if;
  logic                           valid;
  logic                           ready;
  logic [wpbb_pkg::SPAGE_W-1:0]   screen_page;
  logic [wpbb_pkg::SCOL_W-1:0]    screen_column;
  logic [wpbb_pkg::BYTE_W-1:0]    or_mask;
  logic                           last;

  modport source (output valid, screen_page, screen_column, or_mask, last, input ready);
  modport sink   (input valid, screen_page, screen_column, or_mask, last, output ready);
endinterface

>>> rtl/wrapping_page_bitmap_blitter.sv
// top level of the wrapping page bitmap blitter: config registers, pipeline, output stage
// depends on wpbb_pkg, wpbb_in_if, wpbb_out_if, wpbb_mod_pipe and the defines header
`include "wrapping_page_bitmap_blitter_defines.svh"

// Places one byte of a page-organized monochrome bitmap (eight vertical pixels,
// bit 0 on top) onto a 128x64 page-organized screen and returns an or-mask for
// each screen page the byte touches, at most two, lowest target page first,
// with last set on the final one. Zero bytes, bytes outside the configured
// bitmap, bytes whose column lands off screen or in the blank wrap gap, and
// bytes whose rows are all clipped give no result. Bitmaps wider than 128
// columns scroll circularly over width + 64 columns; the others are only
// shifted by scroll_x. pready is always high. The input takes one transaction
// every cycle while the pipeline advances; the output stage sends one mask per
// cycle while the receiver is ready, so a byte that yields two masks stalls the
// pipeline and throughput is one byte per cycle for bytes with at most one mask.
// From input to first mask a byte passes one stage for the column difference
// and row base, one for the magnitude and page masks, four for the wrap modulo
// (two quotient bits each) and the output stage, which all advance together
// when the output stage can take a new byte. The user must write registers over
// the APB-style port only while no byte is in flight; the block does not enforce it.
module wrapping_page_bitmap_blitter (
  input  logic                              clk,
  input  logic                              rst_n,
  wpbb_in_if.sink                           in_ch,
  wpbb_out_if.source                        out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [wpbb_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [wpbb_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [wpbb_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [wpbb_pkg::COL_W-1:0]          width_r;
  logic [wpbb_pkg::NPAGE_W-1:0]        pages_r;
  logic signed [wpbb_pkg::YOFF_W-1:0]  yoff_r;
  logic signed [wpbb_pkg::SCRL_W-1:0]  scroll_r;
  logic                                flip_r;

  logic                                cfg_wr;
  logic [wpbb_pkg::REG_IDX_W-1:0]      cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  // registers sit on 4-byte boundaries
  assign cfg_idx    = cfg_paddr[wpbb_pkg::CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= wpbb_pkg::COL_W'(wpbb_pkg::RST_BITMAP_WIDTH);
      pages_r  <= wpbb_pkg::NPAGE_W'(wpbb_pkg::RST_BITMAP_PAGES);
      yoff_r   <= '0;
      scroll_r <= '0;
      flip_r   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        wpbb_pkg::REG_BITMAP_WIDTH: width_r  <= cfg_pwdata[wpbb_pkg::COL_W-1:0];
        wpbb_pkg::REG_BITMAP_PAGES: pages_r  <= cfg_pwdata[wpbb_pkg::NPAGE_W-1:0];
        wpbb_pkg::REG_Y_OFFSET:     yoff_r   <= $signed(cfg_pwdata[wpbb_pkg::YOFF_W-1:0]);
        wpbb_pkg::REG_SCROLL_X:     scroll_r <= $signed(cfg_pwdata[wpbb_pkg::SCRL_W-1:0]);
        wpbb_pkg::REG_FLIP:         flip_r   <= cfg_pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // read back raw register bits, zero extended
  always_comb begin
    unique case (cfg_idx)
      wpbb_pkg::REG_BITMAP_WIDTH: cfg_prdata = wpbb_pkg::CFG_DATA_W'(width_r);
      wpbb_pkg::REG_BITMAP_PAGES: cfg_prdata = wpbb_pkg::CFG_DATA_W'(pages_r);
      wpbb_pkg::REG_Y_OFFSET:     cfg_prdata = wpbb_pkg::CFG_DATA_W'($unsigned(yoff_r));
      wpbb_pkg::REG_SCROLL_X:     cfg_prdata = wpbb_pkg::CFG_DATA_W'($unsigned(scroll_r));
      wpbb_pkg::REG_FLIP:         cfg_prdata = wpbb_pkg::CFG_DATA_W'(flip_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  // derived configuration, stable while items are in flight if registers are not written meanwhile
  logic                        wrap;
  logic [wpbb_pkg::MOD_W-1:0]  modulus;

  assign wrap    = width_r > wpbb_pkg::COL_W'(wpbb_pkg::SCREEN_WIDTH);
  assign modulus = wpbb_pkg::MOD_W'(width_r) + wpbb_pkg::MOD_W'(wpbb_pkg::WRAP_GAP);

  // the whole pipeline moves when the output stage can take a byte
  logic adv;

  // ---------------------------------------------------------------------
  // stage 1: column difference, row base and discard checks
  // ---------------------------------------------------------------------
  logic                              v1_r;
  logic signed [wpbb_pkg::D_W-1:0]   d1_r;
  logic signed [wpbb_pkg::B_W-1:0]   base1_r;
  logic                              kill1_r;
  logic [wpbb_pkg::BYTE_W-1:0]       byte1_r;

  logic signed [wpbb_pkg::D_W-1:0]   d1_nxt;
  logic signed [wpbb_pkg::B_W-1:0]   base1_nxt;
  logic                              kill1_nxt;

  always_comb begin
    d1_nxt    = $signed(wpbb_pkg::D_W'(in_ch.src_column)) - wpbb_pkg::D_W'(scroll_r);
    base1_nxt = wpbb_pkg::B_W'(yoff_r) + $signed(wpbb_pkg::B_W'({in_ch.src_page, 3'b000}));
    kill1_nxt = (in_ch.src_byte == '0) ||
                (in_ch.src_column >= width_r) ||
                (wpbb_pkg::NPAGE_W'(in_ch.src_page) >= pages_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r    <= d1_nxt;
      base1_r <= base1_nxt;
      kill1_r <= kill1_nxt;
      byte1_r <= in_ch.src_byte;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: magnitude for the modulo, direct column, page masks
  // ---------------------------------------------------------------------
  logic                              v2_r;
  logic [wpbb_pkg::MAG_W-1:0]        mag2_r;
  wpbb_pkg::side_t                   side2_r;

  logic [wpbb_pkg::D_W-1:0]          absd;
  logic [wpbb_pkg::MAG_W-1:0]        mag2_nxt;
  wpbb_pkg::side_t                   side2_nxt;
  logic signed [wpbb_pkg::P_W-1:0]   p0;
  logic signed [wpbb_pkg::P_W-1:0]   p1;
  logic [2*wpbb_pkg::BYTE_W-1:0]     sh;
  logic [wpbb_pkg::BYTE_W-1:0]       lo_m;
  logic [wpbb_pkg::BYTE_W-1:0]       hi_m;
  logic                              lo_v;
  logic                              hi_v;
  logic                              fst_v;
  logic [wpbb_pkg::SPAGE_W-1:0]      fst_pg;
  logic [wpbb_pkg::BYTE_W-1:0]       fst_m;
  logic                              snd_v;
  logic [wpbb_pkg::SPAGE_W-1:0]      snd_pg;
  logic [wpbb_pkg::BYTE_W-1:0]       snd_m;

  always_comb begin
    absd     = d1_r[wpbb_pkg::D_W-1] ? wpbb_pkg::D_W'(-d1_r) : wpbb_pkg::D_W'(d1_r);
    // only wrapping bitmaps go through the modulo, others feed zero
    mag2_nxt = wrap ? absd[wpbb_pkg::MAG_W-1:0] : '0;

    // the eight rows of the byte straddle at most two screen pages
    p0   = $signed(base1_r[wpbb_pkg::B_W-1:3]);
    p1   = p0 + wpbb_pkg::P_W'(1);
    sh   = (2*wpbb_pkg::BYTE_W)'(byte1_r) << base1_r[2:0];
    lo_m = sh[wpbb_pkg::BYTE_W-1:0];
    hi_m = sh[2*wpbb_pkg::BYTE_W-1:wpbb_pkg::BYTE_W];
    lo_v = (p0 >= 0) && (p0 < wpbb_pkg::SCREEN_PAGES) && (lo_m != '0);
    hi_v = (p1 >= 0) && (p1 < wpbb_pkg::SCREEN_PAGES) && (hi_m != '0);

    // flipped, the lower source page becomes the higher screen page
    if (flip_r) begin
      fst_v  = hi_v;
      fst_pg = wpbb_pkg::SPAGE_W'(wpbb_pkg::SCREEN_PAGES - 1) - p1[wpbb_pkg::SPAGE_W-1:0];
      fst_m  = wpbb_pkg::rev8(hi_m);
      snd_v  = lo_v;
      snd_pg = wpbb_pkg::SPAGE_W'(wpbb_pkg::SCREEN_PAGES - 1) - p0[wpbb_pkg::SPAGE_W-1:0];
      snd_m  = wpbb_pkg::rev8(lo_m);
    end else begin
      fst_v  = lo_v;
      fst_pg = p0[wpbb_pkg::SPAGE_W-1:0];
      fst_m  = lo_m;
      snd_v  = hi_v;
      snd_pg = p1[wpbb_pkg::SPAGE_W-1:0];
      snd_m  = hi_m;
    end

    side2_nxt.kill  = kill1_r;
    side2_nxt.neg   = d1_r[wpbb_pkg::D_W-1];
    side2_nxt.nw_ok = !d1_r[wpbb_pkg::D_W-1] &&
                      (d1_r < wpbb_pkg::D_W'(wpbb_pkg::SCREEN_WIDTH));
    side2_nxt.nw_x  = d1_r[wpbb_pkg::SCOL_W-1:0];
    // slot a always holds the first mask to send
    side2_nxt.a_v   = fst_v || snd_v;
    side2_nxt.a_pg  = fst_v ? fst_pg : snd_pg;
    side2_nxt.a_m   = fst_v ? fst_m  : snd_m;
    side2_nxt.b_v   = fst_v && snd_v;
    side2_nxt.b_pg  = snd_pg;
    side2_nxt.b_m   = snd_m;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag2_r  <= mag2_nxt;
      side2_r <= side2_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // stages 3 to 6: wrap modulo
  // ---------------------------------------------------------------------
  logic                        mv;
  logic [wpbb_pkg::MOD_W-1:0]  mrem;
  wpbb_pkg::side_t             mside;

  wpbb_mod_pipe u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .vld_i     (v2_r),
    .mag_i     (mag2_r),
    .modulus_i (modulus),
    .side_i    (side2_r),
    .vld_o     (mv),
    .rem_o     (mrem),
    .side_o    (mside)
  );

  // final column: fold negative differences back into the period, then flip
  logic [wpbb_pkg::MOD_W-1:0]   xw;
  logic                         col_ok;
  logic [wpbb_pkg::SCOL_W-1:0]  x_pre;
  logic [wpbb_pkg::SCOL_W-1:0]  x_fin;
  logic                         ld_a;
  logic                         ld_b;

  always_comb begin
    xw     = (mside.neg && (mrem != '0)) ? (modulus - mrem) : mrem;
    col_ok = wrap ? (xw < wpbb_pkg::MOD_W'(wpbb_pkg::SCREEN_WIDTH)) : mside.nw_ok;
    x_pre  = wrap ? xw[wpbb_pkg::SCOL_W-1:0] : mside.nw_x;
    x_fin  = flip_r ? (wpbb_pkg::SCOL_W'(wpbb_pkg::SCREEN_WIDTH - 1) - x_pre) : x_pre;
    ld_a   = mv && !mside.kill && col_ok && mside.a_v;
    ld_b   = ld_a && mside.b_v;
  end

  // ---------------------------------------------------------------------
  // stage 7: output stage, two mask slots sent in order
  // ---------------------------------------------------------------------
  logic                          ova_r;
  logic                          ovb_r;
  logic [wpbb_pkg::SCOL_W-1:0]   col_r;
  logic [wpbb_pkg::SPAGE_W-1:0]  pga_r;
  logic [wpbb_pkg::BYTE_W-1:0]   ma_r;
  logic [wpbb_pkg::SPAGE_W-1:0]  pgb_r;
  logic [wpbb_pkg::BYTE_W-1:0]   mb_r;

  // free when empty, or when the single remaining mask leaves this cycle
  assign adv         = !(ova_r || ovb_r) || (out_ch.ready && (ova_r ^ ovb_r));
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ova_r <= 1'b0;
      ovb_r <= 1'b0;
    end else if (adv) begin
      ova_r <= ld_a;
      ovb_r <= ld_b;
    end else if (out_ch.ready) begin
      // both pending: the first one leaves
      ova_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      col_r <= x_fin;
      pga_r <= mside.a_pg;
      ma_r  <= mside.a_m;
      pgb_r <= mside.b_pg;
      mb_r  <= mside.b_m;
    end
  end

  assign out_ch.valid         = ova_r || ovb_r;
  assign out_ch.screen_page   = ova_r ? pga_r : pgb_r;
  assign out_ch.screen_column = col_r;
  assign out_ch.or_mask       = ova_r ? ma_r : mb_r;
  assign out_ch.last          = !(ova_r && ovb_r);

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  `WPBB_ASSERT(a_mask_nonzero, !out_ch.valid || (out_ch.or_mask != '0), "empty or-mask sent")
  `WPBB_ASSERT(a_page_order, !(ova_r && ovb_r) || (pga_r < pgb_r), "masks out of page order")
  `WPBB_ASSERT_NEXT(a_pair_drain, ova_r && ovb_r && out_ch.ready, !ova_r && ovb_r, "second mask lost")

endmodule

>>> rtl/wpbb_mod_pipe.sv
// pipelined restoring modulo, two quotient bits per stage, with sideband
// depends on wpbb_pkg
module wpbb_mod_pipe (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         vld_i,
  input  logic [wpbb_pkg::MAG_W-1:0]   mag_i,
  input  logic [wpbb_pkg::MOD_W-1:0]   modulus_i,
  input  wpbb_pkg::side_t              side_i,
  output logic                         vld_o,
  output logic [wpbb_pkg::MOD_W-1:0]   rem_o,
  output wpbb_pkg::side_t              side_o
);

  localparam int STAGES = wpbb_pkg::MOD_STAGES;

  logic [STAGES-1:0]          vld_r;
  logic [wpbb_pkg::MAG_W-1:0] rem_r  [STAGES];
  wpbb_pkg::side_t            side_r [STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[STAGES-2:0], vld_i};
    end
  end

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    logic [wpbb_pkg::MAG_W-1:0] rem_in;
    logic [wpbb_pkg::MAG_W-1:0] rem_nxt;
    wpbb_pkg::side_t            side_in;

    if (j == 0) begin : g_first
      assign rem_in  = mag_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign side_in = side_r[j-1];
    end

    // high quotient bit first
    assign rem_nxt = wpbb_pkg::mod_step(
                       wpbb_pkg::mod_step(rem_in, modulus_i, wpbb_pkg::QUO_W - 1 - 2*j),
                       modulus_i, wpbb_pkg::QUO_W - 2 - 2*j);

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[j]  <= rem_nxt;
        side_r[j] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[STAGES-1];
  assign rem_o  = rem_r[STAGES-1][wpbb_pkg::MOD_W-1:0];
  assign side_o = side_r[STAGES-1];

endmodule

>>> tb/tb_wrapping_page_bitmap_blitter.sv
// self-checking testbench of the wrapping page bitmap blitter
// depends on wpbb_pkg, wpbb_in_if, wpbb_out_if and the blitter top level
`timescale 1ns / 100ps

module tb_wrapping_page_bitmap_blitter;
  import wpbb_pkg::*;

  // run length and pacing
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 93;
  localparam int HOLD_PHASE      = 2;      // phase with the long receiver hold-off
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 12;     // pipeline latency plus margin
  localparam int MAX_GAP         = 12;
  localparam int LIMIT_CYCLES    = 200000;

  // one or-mask as the receiver sees it
  typedef struct packed {
    logic [SPAGE_W-1:0] screen_page;
    logic [SCOL_W-1:0]  screen_column;
    logic [BYTE_W-1:0]  or_mask;
    logic               last;
  } placed_mask_t;

  // register copy, placement of each accepted byte and the masks still owed
  class mask_scoreboard;
    int  bitmap_width;
    int  bitmap_pages;
    int  y_offset;
    int  scroll_x;
    bit  flip;
    int  errors;
    placed_mask_t pending_masks[$];

    function new();
      bitmap_width = RST_BITMAP_WIDTH;
      bitmap_pages = RST_BITMAP_PAGES;
      y_offset     = 0;
      scroll_x     = 0;
      flip         = 1'b0;
      errors       = 0;
    endfunction

    function void write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
      case (idx)
        REG_BITMAP_WIDTH: bitmap_width = int'(data[COL_W-1:0]);
        REG_BITMAP_PAGES: bitmap_pages = int'(data[NPAGE_W-1:0]);
        REG_Y_OFFSET:     y_offset     = int'($signed(data[YOFF_W-1:0]));
        REG_SCROLL_X:     scroll_x     = int'($signed(data[SCRL_W-1:0]));
        REG_FLIP:         flip         = data[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_masks.size();
    endfunction

    // works out the masks one accepted byte places on the screen
    function void place_byte(input logic [COL_W-1:0] src_column,
                             input logic [PAGE_W-1:0] src_page,
                             input logic [BYTE_W-1:0] src_byte);
      int col;
      int pg;
      int x;
      int period;
      int row;
      int tp;
      int n;
      int tpage[2];
      logic [BYTE_W-1:0] tmask[2];
      int swap_pg;
      logic [BYTE_W-1:0] swap_m;
      placed_mask_t m;
      col = int'(src_column);
      pg  = int'(src_page);
      n   = 0;
      if (src_byte == '0 || col >= bitmap_width || pg >= bitmap_pages) return;
      if (bitmap_width > SCREEN_WIDTH) begin
        period = bitmap_width + WRAP_GAP;
        x = (col - scroll_x) % period;
        if (x < 0) x += period;
      end else begin
        x = col - scroll_x;
      end
      if (x < 0 || x >= SCREEN_WIDTH) return;
      if (flip) x = SCREEN_WIDTH - 1 - x;
      for (int i = 0; i < BYTE_W; i++) begin
        if (src_byte[i]) begin
          row = y_offset + pg * 8 + i;
          if (row >= 0 && row < SCREEN_HEIGHT) begin
            if (flip) row = SCREEN_HEIGHT - 1 - row;
            tp = row >> 3;
            if (n > 0 && tpage[0] == tp) begin
              tmask[0][row & 7] = 1'b1;
            end else if (n > 1 && tpage[1] == tp) begin
              tmask[1][row & 7] = 1'b1;
            end else if (n < 2) begin
              tpage[n] = tp;
              tmask[n] = '0;
              tmask[n][row & 7] = 1'b1;
              n++;
            end
          end
        end
      end
      // lowest target page goes out first
      if (n == 2 && tpage[0] > tpage[1]) begin
        swap_pg  = tpage[0];
        swap_m   = tmask[0];
        tpage[0] = tpage[1];
        tmask[0] = tmask[1];
        tpage[1] = swap_pg;
        tmask[1] = swap_m;
      end
      for (int k = 0; k < n; k++) begin
        m.screen_page   = tpage[k][SPAGE_W-1:0];
        m.screen_column = x[SCOL_W-1:0];
        m.or_mask       = tmask[k];
        m.last          = (k == n - 1);
        pending_masks.push_back(m);
      end
    endfunction

    function void check_mask(input placed_mask_t got);
      placed_mask_t want;
      if (pending_masks.size() == 0) begin
        $error("unexpected or-mask: page %0d column %0d mask %02h last %0b",
               got.screen_page, got.screen_column, got.or_mask, got.last);
        errors++;
        return;
      end
      want = pending_masks.pop_front();
      if (got.screen_page !== want.screen_page) begin
        $error("screen_page mismatch: expected %0d, actual %0d",
               want.screen_page, got.screen_page);
        errors++;
      end
      if (got.screen_column !== want.screen_column) begin
        $error("screen_column mismatch: expected %0d, actual %0d",
               want.screen_column, got.screen_column);
        errors++;
      end
      if (got.or_mask !== want.or_mask) begin
        $error("or_mask mismatch: expected %02h, actual %02h", want.or_mask, got.or_mask);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last mismatch: expected %0b, actual %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  wpbb_in_if  in_ch();
  wpbb_out_if out_ch();

  mask_scoreboard board = new();

  int cycle_count = 0;
  bit out_gappy     = 1'b0;   // receiver draws random stalls when set
  bit hold_off_req  = 1'b0;   // asks the receiver for one long hold-off

  wrapping_page_bitmap_blitter i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: a hung handshake or a lost mask ends here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int draw_gap(input bit gappy);
    return gappy ? int'($urandom_range(0, MAX_GAP)) : 0;
  endfunction

  // one bitmap byte per transaction; valid stays up between back-to-back bytes
  task automatic send_byte(input logic [COL_W-1:0] src_column,
                           input logic [PAGE_W-1:0] src_page,
                           input logic [BYTE_W-1:0] src_byte,
                           input bit gappy);
    int gap;
    gap = draw_gap(gappy);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.src_column <= src_column;
    in_ch.src_page   <= src_page;
    in_ch.src_byte   <= src_byte;
    do @(posedge clk); while (!in_ch.ready);
    // transaction taken at this edge
    board.place_byte(src_column, src_page, src_byte);
  endtask

  // apb setup and access cycles; select is dropped by cfg_release after a batch
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    board.write_reg(idx, data);
  endtask

  task automatic cfg_release();
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // writes every register, values given as plain integers
  task automatic apply_settings(input int width, input int pages, input int yoff,
                                input int scroll, input int flip_on);
    write_reg(REG_BITMAP_WIDTH, 32'(width) & 32'h0000_1FFF);
    write_reg(REG_BITMAP_PAGES, 32'(pages) & 32'h0000_003F);
    write_reg(REG_Y_OFFSET,     32'(yoff) & 32'h0000_00FF);
    write_reg(REG_SCROLL_X,     32'(scroll) & 32'h0000_FFFF);
    write_reg(REG_FLIP,         32'(flip_on) & 32'h0000_0001);
    cfg_release();
  endtask

  // stop offering bytes, wait for every owed mask, then let the pipe drain
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_settings();
    int w;
    int p;
    int y;
    int s;
    case ($urandom_range(0, 5))
      0:       w = 1;
      1:       w = SCREEN_WIDTH;
      2:       w = SCREEN_WIDTH + 1;
      3:       w = 8191;
      4:       w = $urandom_range(SCREEN_WIDTH + 1, 600);
      default: w = $urandom_range(1, SCREEN_WIDTH - 1);
    endcase
    case ($urandom_range(0, 4))
      0:       p = 1;
      1:       p = 32;
      2:       p = 63;
      default: p = $urandom_range(1, 32);
    endcase
    case ($urandom_range(0, 5))
      0:       y = -128;
      1:       y = 127;
      default: y = int'($urandom_range(0, 79)) - 16;
    endcase
    case ($urandom_range(0, 5))
      0:       s = -32768;
      1:       s = 32767;
      default: begin
        // wide bitmaps wrap so any scroll lands somewhere; narrow ones need aiming
        if (w > SCREEN_WIDTH) s = $urandom_range(0, 65535);
        else s = int'($urandom_range(0, w + SCREEN_WIDTH - 2)) - (SCREEN_WIDTH - 1);
      end
    endcase
    apply_settings(w, p, y, s, $urandom_range(0, 1));
  endtask

  // mostly bytes aimed at the visible screen, the rest raw noise
  task automatic random_byte(output logic [COL_W-1:0] src_column,
                             output logic [PAGE_W-1:0] src_page,
                             output logic [BYTE_W-1:0] src_byte);
    int x;
    int col;
    int pg;
    int np;
    int period;
    if ($urandom_range(0, 9) < 7 && board.bitmap_width > 0 && board.bitmap_pages > 0) begin
      x = $urandom_range(0, SCREEN_WIDTH - 1);
      if (board.bitmap_width > SCREEN_WIDTH) begin
        period = board.bitmap_width + WRAP_GAP;
        col = (x + board.scroll_x) % period;
        if (col < 0) col += period;
      end else begin
        col = x + board.scroll_x;
      end
      if (col < 0 || col >= board.bitmap_width) col = $urandom_range(0, board.bitmap_width - 1);
      np = (board.bitmap_pages > 32) ? 32 : board.bitmap_pages;
      pg = $urandom_range(0, np - 1);
      // retry for a page whose rows reach the screen
      for (int t = 0; t < 8; t++) begin
        if (board.y_offset + pg * 8 < -7 || board.y_offset + pg * 8 > SCREEN_HEIGHT - 1)
          pg = $urandom_range(0, np - 1);
      end
      src_column = col[COL_W-1:0];
      src_page   = pg[PAGE_W-1:0];
      src_byte   = BYTE_W'($urandom_range(1, 255));
    end else begin
      src_column = COL_W'($urandom);
      src_page   = PAGE_W'($urandom);
      src_byte   = ($urandom_range(0, 7) == 0) ? '0 : BYTE_W'($urandom);
    end
  endtask

  // short directed run over the corners of the placement
  task automatic directed_run();
    bit g;
    g = 1'b1;
    // reset settings: 128 wide, two pages, no offset, no flip
    send_byte(13'd0, 5'd0, 8'hFF, g);
    send_byte(13'd127, 5'd1, 8'h01, g);
    send_byte(13'd0, 5'd0, 8'h00, g);        // zero byte
    send_byte(13'd128, 5'd0, 8'hFF, g);      // column beyond the bitmap
    send_byte(13'd5, 5'd2, 8'hFF, g);        // page beyond the bitmap
    send_byte(13'd8191, 5'd31, 8'hFF, g);
    // wrapping bitmap with a row offset that straddles two screen pages
    wait_idle();
    apply_settings(200, 32, 3, 10, 0);
    send_byte(13'd10, 5'd0, 8'hFF, g);       // two masks
    send_byte(13'd9, 5'd0, 8'h01, g);        // wraps into the blank gap
    send_byte(13'd137, 5'd0, 8'h80, g);      // last screen column
    send_byte(13'd199, 5'd0, 8'hFF, g);
    send_byte(13'd0, 5'd31, 8'hFF, g);       // rows below the screen
    send_byte(13'd0, 5'd7, 8'hFF, g);        // partly clipped rows
    // widest bitmap, extreme offsets, rotated placement
    wait_idle();
    apply_settings(8191, 32, -128, -32768, 1);
    send_byte(13'd252, 5'd16, 8'hFF, g);
    send_byte(13'd252, 5'd16, 8'h01, g);
    send_byte(13'd379, 5'd17, 8'hF0, g);
    send_byte(13'd0, 5'd0, 8'hFF, g);        // rows above the screen
    send_byte(13'd8191, 5'd31, 8'hAA, g);
    // one-column bitmap shifted to the right edge, bottom row only
    wait_idle();
    apply_settings(1, 1, 63, -127, 0);
    send_byte(13'd0, 5'd0, 8'h01, g);
    send_byte(13'd0, 5'd0, 8'hFE, g);
    send_byte(13'd1, 5'd0, 8'hFF, g);
    // empty bitmap: zero width and zero pages
    wait_idle();
    apply_settings(0, 0, 0, 0, 0);
    send_byte(13'd0, 5'd0, 8'hFF, g);
    send_byte(13'd0, 5'd0, 8'h01, g);
    // narrow bitmap scrolled fully off screen
    wait_idle();
    apply_settings(SCREEN_WIDTH, 32, 0, 32767, 1);
    send_byte(13'd0, 5'd0, 8'hFF, g);
  endtask

  // receiver: random stalls per mask, one long hold-off on request
  initial begin
    int gap;
    placed_mask_t got;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = draw_gap(out_gappy);
      if (hold_off_req) begin
        gap = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      // transaction taken at this edge, payload still holds its pre-edge value
      got = '{out_ch.screen_page, out_ch.screen_column, out_ch.or_mask, out_ch.last};
      board.check_mask(got);
    end
  end

  // reset, directed run, random phases, drain and verdict
  initial begin
    logic [COL_W-1:0]  src_column;
    logic [PAGE_W-1:0] src_page;
    logic [BYTE_W-1:0] src_byte;
    bit in_gappy;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.src_column <= '0;
    in_ch.src_page   <= '0;
    in_ch.src_byte   <= '0;
    cfg_psel         <= 1'b0;
    cfg_penable      <= 1'b0;
    cfg_pwrite       <= 1'b0;
    cfg_paddr        <= '0;
    cfg_pwdata       <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    out_gappy = 1'b1;
    directed_run();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      random_settings();
      // some phases run flat out on one or both sides
      in_gappy  = ($urandom_range(0, 3) != 0);
      out_gappy = ($urandom_range(0, 3) != 0);
      if (ph == HOLD_PHASE) begin
        // sender keeps pushing while the receiver sits still, so the pipe backs up
        in_gappy     = 1'b0;
        hold_off_req = 1'b1;
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        random_byte(src_column, src_page, src_byte);
        send_byte(src_column, src_page, src_byte, in_gappy);
      end
    end

    wait_idle();
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
